/* src/mi3_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse.
// Holds the cofactor operand table and the stage control bundle.
// ----------------------------------------------------------------------------
package mi3_pkg;

    // Number of matrix elements and rows.
    localparam int unsigned MI3_N    = 9;
    localparam int unsigned MI3_ROWS = 3;

    // Index of one element in row-major order.
    typedef logic [3:0] mi3_idx_t;

    // Cofactor k is elem[p] * elem[q] - elem[s] * elem[t], listed as {p, q, s, t}.
    localparam mi3_idx_t MINOR_IDX [MI3_N][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // Pipeline advance and the valid bit that enters a module.
    typedef struct packed {
        logic en;
        logic vld;
    } mi3_ctl_t;

endpackage
`default_nettype wire

/* src/mi3_cofactor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_cofactor: adjugate cofactors of a 3x3 matrix.
// Stage one forms the eighteen 2x2 minor products, stage two subtracts them.
// ----------------------------------------------------------------------------
module mi3_cofactor
    import mi3_pkg::*;
#(
    parameter int unsigned ELEM_BITS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mi3_ctl_t                      ctl,
    input  logic signed [ELEM_BITS-1:0]   elem [MI3_N],
    output logic                          vld,
    output logic signed [2*ELEM_BITS:0]   cof  [MI3_N],
    output logic signed [ELEM_BITS-1:0]   row  [MI3_ROWS]
);

    localparam int unsigned PW = 2 * ELEM_BITS;
    localparam int unsigned CW = 2 * ELEM_BITS + 1;

    logic signed [PW-1:0]        pa_next  [MI3_N];
    logic signed [PW-1:0]        pb_next  [MI3_N];
    logic signed [PW-1:0]        pa_reg   [MI3_N];
    logic signed [PW-1:0]        pb_reg   [MI3_N];
    logic signed [CW-1:0]        cof_next [MI3_N];
    logic signed [CW-1:0]        cof_reg  [MI3_N];
    logic signed [ELEM_BITS-1:0] row_a_reg [MI3_ROWS];
    logic signed [ELEM_BITS-1:0] row_b_reg [MI3_ROWS];
    logic                        vld_a_reg;
    logic                        vld_b_reg;

    // Products and differences, one lane per cofactor.
    for (genvar k = 0; k < MI3_N; k++) begin : g_lane
        always_comb
        begin
            pa_next[k]  = elem[MINOR_IDX[k][0]] * elem[MINOR_IDX[k][1]];
            pb_next[k]  = elem[MINOR_IDX[k][2]] * elem[MINOR_IDX[k][3]];
            cof_next[k] = CW'(pa_reg[k]) - CW'(pb_reg[k]);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            cof_reg   <= cof_next;
            row_a_reg <= elem[0:MI3_ROWS-1];
            row_b_reg <= row_a_reg;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            vld_a_reg <= ctl.vld;
            vld_b_reg <= vld_a_reg;
        end
    end

    assign vld = vld_b_reg;
    assign cof = cof_reg;
    assign row = row_b_reg;

endmodule
`default_nettype wire

/* src/mi3_det.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_det: determinant by expansion along the first row.
// Each wide product is split in two partial products, recombined, then summed.
// ----------------------------------------------------------------------------
module mi3_det
    import mi3_pkg::*;
#(
    parameter int unsigned ELEM_BITS = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mi3_ctl_t                      ctl,
    input  logic signed [2*ELEM_BITS:0]   cof     [MI3_N],
    input  logic signed [ELEM_BITS-1:0]   row     [MI3_ROWS],
    output logic                          vld,
    output logic signed [3*ELEM_BITS+2:0] det,
    output logic signed [2*ELEM_BITS:0]   cof_out [MI3_N]
);

    localparam int unsigned CW  = 2 * ELEM_BITS + 1;
    localparam int unsigned LW  = ELEM_BITS + 1;
    localparam int unsigned PLW = 2 * ELEM_BITS + 2;
    localparam int unsigned PHW = 2 * ELEM_BITS;
    localparam int unsigned TW  = 3 * ELEM_BITS + 1;
    localparam int unsigned DTW = 3 * ELEM_BITS + 3;

    logic signed [PLW-1:0] lo_next   [MI3_ROWS];
    logic signed [PHW-1:0] hi_next   [MI3_ROWS];
    logic signed [PLW-1:0] lo_reg    [MI3_ROWS];
    logic signed [PHW-1:0] hi_reg    [MI3_ROWS];
    logic signed [TW-1:0]  term_next [MI3_ROWS];
    logic signed [TW-1:0]  term_reg  [MI3_ROWS];
    logic signed [DTW-1:0] det_next;
    logic signed [DTW-1:0] det_reg;
    logic signed [CW-1:0]  cs1_reg [MI3_N];
    logic signed [CW-1:0]  cs2_reg [MI3_N];
    logic signed [CW-1:0]  cs3_reg [MI3_N];
    logic [2:0]            vld_reg;

    // Row element times its cofactor, split at the low LW bits of the cofactor.
    for (genvar j = 0; j < MI3_ROWS; j++) begin : g_term
        always_comb
        begin
            lo_next[j]   = row[j] * $signed({1'b0, cof[3*j][LW-1:0]});
            hi_next[j]   = row[j] * $signed(cof[3*j][CW-1:LW]);
            term_next[j] = (TW'(hi_reg[j]) <<< LW) + TW'(lo_reg[j]);
        end
    end

    // Sum of the three terms.
    always_comb
    begin
        det_next = DTW'(term_reg[0]) + DTW'(term_reg[1]) + DTW'(term_reg[2]);
    end

    // Payload registers; the cofactors ride along for the divider.
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            term_reg <= term_next;
            det_reg  <= det_next;
            cs1_reg  <= cof;
            cs2_reg  <= cs1_reg;
            cs3_reg  <= cs2_reg;
        end
    end

    // Valid bits for the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.en)
        begin
            vld_reg <= {vld_reg[1:0], ctl.vld};
        end
    end

    assign vld     = vld_reg[2];
    assign det     = det_reg;
    assign cof_out = cs3_reg;

endmodule
`default_nettype wire

/* src/mi3_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_div: pipelined restoring divider with signed saturation.
// First stage detects a quotient too large for the element, then one quotient
// bit per stage, then a final stage clips and applies the sign.
// ----------------------------------------------------------------------------
module mi3_div
#(
    parameter int unsigned ELEM_BITS = 32,
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic                                    clk,
    input  logic                                    en,
    input  logic [2*ELEM_BITS+2*FRAC_BITS:0]        num,
    input  logic [3*ELEM_BITS+2:0]                  den,
    input  logic                                    neg,
    output logic signed [ELEM_BITS-1:0]             res
);

    localparam int unsigned E  = ELEM_BITS;
    localparam int unsigned NW = 2 * ELEM_BITS + 2 * FRAC_BITS + 1;
    localparam int unsigned DW = 3 * ELEM_BITS + 3;
    localparam int unsigned RW = (NW > DW + E) ? NW : DW + E;

    logic [RW-1:0]  rem_reg  [E];
    logic [RW-1:0]  rem_next [E];
    logic [DW-1:0]  den_reg  [E];
    logic [E-1:0]   quo_reg  [E+1];
    logic [E-1:0]   quo_next [E+1];
    logic           ovf_reg  [E+1];
    logic           ovf_next [E+1];
    logic           neg_reg  [E+1];
    logic [E-1:0]   lim;
    logic [E-1:0]   mag;
    logic signed [E-1:0] res_next;
    logic signed [E-1:0] res_reg;

    for (genvar s = 0; s <= E; s++) begin : g_step
        logic [RW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [RW-1:0] dsh;
        logic          ge;

        if (s == 0) begin : g_first
            assign rem_in = RW'(num);
            assign den_in = den;
        end
        else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        assign dsh = RW'(den_in) << (E - s);
        assign ge  = rem_in >= dsh;

        if (s == 0) begin : g_ovf
            // Quotient would need more than E bits.
            always_comb
            begin
                quo_next[s] = '0;
                ovf_next[s] = ge;
                rem_next[s] = rem_in;
            end
        end
        else begin : g_bit
            // One quotient bit, weight E - s.
            always_comb
            begin
                quo_next[s] = quo_reg[s-1];
                ovf_next[s] = ovf_reg[s-1];
                if (ge && !ovf_reg[s-1])
                begin
                    quo_next[s][E-s] = 1'b1;
                end
            end

            // Partial remainder for the next stage.
            if (s < E) begin : g_rem
                always_comb
                begin
                    rem_next[s] = (ge && !ovf_reg[s-1]) ? rem_in - dsh : rem_in;
                end
            end
        end

        // Stage registers.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[s] <= quo_next[s];
                ovf_reg[s] <= ovf_next[s];
            end
        end

        // The quotient sign travels with the stage.
        if (s == 0) begin : g_neg_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    neg_reg[s] <= neg;
                end
            end
        end
        else begin : g_neg_rest
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    neg_reg[s] <= neg_reg[s-1];
                end
            end
        end

        // Remainder and divisor for every stage that feeds another.
        if (s < E) begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= rem_next[s];
                    den_reg[s] <= den_in;
                end
            end
        end
    end

    // Clip to the element range and apply the sign.
    always_comb
    begin
        lim      = neg_reg[E] ? {1'b1, {(E-1){1'b0}}} : {1'b0, {(E-1){1'b1}}};
        mag      = (ovf_reg[E] || (quo_reg[E] > lim)) ? lim : quo_reg[E];
        res_next = neg_reg[E] ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire

/* src/matrix_inverse_3x3.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: inverse of a signed fixed-point 3x3 matrix by adjugate.
// Cofactors and determinant are exact; each inverse element is the cofactor
// divided by the determinant, truncated and saturated. A zero determinant
// gives the identity and raises singular.
//
//   channel  | valid      | stall      | beat
//   ---------+------------+------------+-------------------------------------
//   matrix   | mat_valid  | mat_stall  | a00..a22
//   inverse  | inv_valid  | inv_stall  | r00..r22, det_value, singular
//
// One matrix per cycle is accepted while mat_stall is low; the divider
// resolves one quotient bit per stage.
// Reset clears all valid bits; no data path register is reset.
// A stalled result freezes the whole pipeline; nothing is lost or repeated,
// and an empty output register lets the pipeline run on.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3
    import mi3_pkg::*;
#(
    parameter int unsigned ELEM_BITS = 32,
    parameter int unsigned FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        mat_valid,
    output logic                        mat_stall,
    input  logic signed [ELEM_BITS-1:0] a00,
    input  logic signed [ELEM_BITS-1:0] a01,
    input  logic signed [ELEM_BITS-1:0] a02,
    input  logic signed [ELEM_BITS-1:0] a10,
    input  logic signed [ELEM_BITS-1:0] a11,
    input  logic signed [ELEM_BITS-1:0] a12,
    input  logic signed [ELEM_BITS-1:0] a20,
    input  logic signed [ELEM_BITS-1:0] a21,
    input  logic signed [ELEM_BITS-1:0] a22,
    output logic                        inv_valid,
    input  logic                        inv_stall,
    output logic signed [ELEM_BITS-1:0] r00,
    output logic signed [ELEM_BITS-1:0] r01,
    output logic signed [ELEM_BITS-1:0] r02,
    output logic signed [ELEM_BITS-1:0] r10,
    output logic signed [ELEM_BITS-1:0] r11,
    output logic signed [ELEM_BITS-1:0] r12,
    output logic signed [ELEM_BITS-1:0] r20,
    output logic signed [ELEM_BITS-1:0] r21,
    output logic signed [ELEM_BITS-1:0] r22,
    output logic signed [ELEM_BITS-1:0] det_value,
    output logic                        singular
);

    localparam int unsigned E   = ELEM_BITS;
    localparam int unsigned CW  = 2 * ELEM_BITS + 1;
    localparam int unsigned NW  = 2 * ELEM_BITS + 2 * FRAC_BITS + 1;
    localparam int unsigned DW  = 3 * ELEM_BITS + 3;
    localparam int unsigned DLY = ELEM_BITS + 2;
    localparam logic [E-1:0] ONE = (FRAC_BITS < ELEM_BITS - 1) ?
                                   (E'(1) << FRAC_BITS) : {1'b0, {(E-1){1'b1}}};

    logic                 en;
    logic signed [E-1:0]  elem [MI3_N];
    logic                 cof_vld;
    logic signed [CW-1:0] cof [MI3_N];
    logic signed [E-1:0]  row [MI3_ROWS];
    logic                 det_vld;
    logic signed [DW-1:0] det;
    logic signed [CW-1:0] cof_d [MI3_N];

    // Preparation stage signals.
    logic [CW-1:0]        cmag [MI3_N];
    logic [NW-1:0]        num_next [MI3_N];
    logic [NW-1:0]        num_reg  [MI3_N];
    logic                 neg_next [MI3_N];
    logic                 neg_reg  [MI3_N];
    logic [DW-1:0]        den_next;
    logic [DW-1:0]        den_reg;
    logic [DW-1:0]        dq;
    logic [E-1:0]         dlim;
    logic [E-1:0]         dmag;
    logic signed [E-1:0]  dval_next;
    logic                 sing_next;

    // Side chain alongside the divider; bit i lines up with dval_reg[i].
    logic signed [E-1:0]  dval_reg [DLY+1];
    logic                 sing_reg [DLY+1];
    logic [DLY:0]         pipe_vld_reg;
    logic signed [E-1:0]  quot [MI3_N];

    // Output register.
    logic signed [E-1:0]  out_next [MI3_N];
    logic signed [E-1:0]  out_reg  [MI3_N];
    logic signed [E-1:0]  det_out_reg;
    logic                 sing_out_reg;
    logic                 out_vld_reg;

    // The pipeline advances unless a result is held at the output.
    assign en        = !(out_vld_reg && inv_stall);
    assign mat_stall = !en;

    assign elem = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

    mi3_cofactor #(
        .ELEM_BITS (ELEM_BITS)
    ) u_cofactor (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   ('{en: en, vld: mat_valid}),
        .elem  (elem),
        .vld   (cof_vld),
        .cof   (cof),
        .row   (row)
    );

    mi3_det #(
        .ELEM_BITS (ELEM_BITS)
    ) u_det (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     ('{en: en, vld: cof_vld}),
        .cof     (cof),
        .row     (row),
        .vld     (det_vld),
        .det     (det),
        .cof_out (cof_d)
    );

    // Magnitudes and signs for the dividers; scaled and saturated determinant.
    always_comb
    begin
        den_next  = det[DW-1] ? DW'(-det) : DW'(det);
        sing_next = (det == '0);
        dq        = den_next >> (2 * FRAC_BITS);
        dlim      = det[DW-1] ? {1'b1, {(E-1){1'b0}}} : {1'b0, {(E-1){1'b1}}};
        dmag      = (dq > DW'(dlim)) ? dlim : dq[E-1:0];
        dval_next = det[DW-1] ? -$signed(dmag) : $signed(dmag);
    end

    for (genvar k = 0; k < MI3_N; k++) begin : g_prep
        always_comb
        begin
            cmag[k]     = cof_d[k][CW-1] ? CW'(-cof_d[k]) : CW'(cof_d[k]);
            num_next[k] = NW'(cmag[k]) << (2 * FRAC_BITS);
            neg_next[k] = cof_d[k][CW-1] ^ det[DW-1];
        end

        mi3_div #(
            .ELEM_BITS (ELEM_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[k]),
            .den (den_reg),
            .neg (neg_reg[k]),
            .res (quot[k])
        );

        // Identity on the diagonal when the matrix is singular.
        always_comb
        begin
            if (sing_reg[DLY])
            begin
                out_next[k] = (k % 4 == 0) ? $signed(ONE) : '0;
            end
            else
            begin
                out_next[k] = quot[k];
            end
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg     <= num_next;
            neg_reg     <= neg_next;
            den_reg     <= den_next;
            dval_reg[0] <= dval_next;
            sing_reg[0] <= sing_next;
            for (int i = 1; i <= DLY; i++)
            begin
                dval_reg[i] <= dval_reg[i-1];
                sing_reg[i] <= sing_reg[i-1];
            end
            out_reg      <= out_next;
            det_out_reg  <= dval_reg[DLY];
            sing_out_reg <= sing_reg[DLY];
        end
    end

    // Valid bits from the preparation stage to the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else if (en)
        begin
            pipe_vld_reg <= {pipe_vld_reg[DLY-1:0], det_vld};
            out_vld_reg  <= pipe_vld_reg[DLY];
        end
    end

    assign inv_valid = out_vld_reg;
    assign r00       = out_reg[0];
    assign r01       = out_reg[1];
    assign r02       = out_reg[2];
    assign r10       = out_reg[3];
    assign r11       = out_reg[4];
    assign r12       = out_reg[5];
    assign r20       = out_reg[6];
    assign r21       = out_reg[7];
    assign r22       = out_reg[8];
    assign det_value = det_out_reg;
    assign singular  = sing_out_reg;

    // A singular result reports a zero determinant.
    a_sing_det: assert property (@(posedge clk) disable iff (!rst_n)
        (inv_valid && singular) |-> (det_value == '0))
        else $error("singular beat with nonzero determinant");

    // A singular result carries the identity.
    a_sing_id: assert property (@(posedge clk) disable iff (!rst_n)
        (inv_valid && singular) |-> (r01 == '0 && r10 == '0 && r22 == $signed(ONE)))
        else $error("singular beat without identity");

    // A held result keeps the input side stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (inv_valid && inv_stall) |-> mat_stall)
        else $error("input accepted while output held");

endmodule
`default_nettype wire
